// File: rtl/vmc_pkg.sv
// vmc_pkg: types and constants shared by the vend motor cycle controller
// no dependencies; imported by vmc_addr_decode and vend_motor_cycle_controller
`timescale 1ns / 1ps

package vmc_pkg;

    // cycle phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CHECK  = 2'd1,
        PH_LEAVE  = 2'd2,
        PH_RETURN = 2'd3
    } t_phase;

    // completion codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_HOME   = 3'd1,
        ST_BAD_ADDR   = 3'd2,
        ST_STUCK_HOME = 3'd3,
        ST_STUCK_AWAY = 3'd4,
        ST_NO_CAN     = 3'd5
    } t_status;

    // request kinds carried on tuser
    localparam logic REQ_VEND = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHILLER      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_LIMIT = 2'd2;

    localparam int unsigned LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LEAVE_LIMIT_RST  = 7'd20;
    localparam logic [LIMIT_W-1:0] RETURN_LIMIT_RST = 7'd80;

    // address characters
    localparam logic [7:0] ROW_A    = 8'h41;
    localparam logic [7:0] ROW_D    = 8'h44;
    localparam logic [7:0] ROW_E    = 8'h45;
    localparam logic [7:0] ROW_F    = 8'h46;
    localparam logic [7:0] ROW_G    = 8'h47;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] ADDR_LEN = 8'd2;

    localparam logic [7:0] CHILLER_BIT = 8'h10;

    // sensor line numbers for the drink rows
    localparam logic [2:0] HOME_LINE_E = 3'd4;
    localparam logic [2:0] CAN_LINE_E  = 3'd5;
    localparam logic [2:0] HOME_LINE_F = 3'd6;
    localparam logic [2:0] CAN_LINE_F  = 3'd7;

    // decoded vend address
    typedef struct packed {
        logic        valid;
        logic [23:0] drive;
        logic [2:0]  home_line;
        logic [2:0]  can_line;
        logic        drink_row;
    } t_vend_setup;

endpackage

// File: rtl/vend_motor_cycle_controller.sv
// vend_motor_cycle_controller: top level, vend cycle sequencer with result register
// depends on vmc_pkg and vmc_addr_decode
`timescale 1ns / 1ps

// channel   direction  handshake                    content
// s         in         i_s_tvalid / o_s_tready      vend request or sensor tick
// m         out        o_m_tvalid / i_m_tready      latch bytes and status
// cfg       in         i_cfg_valid / o_cfg_ready    register index and value
//
// one item per cycle while no result is stalled; each accepted item yields one result in the
// next cycle, set by the single result register after the phase logic
// reset is synchronous, active low: phase idle, latches off, limits 20 and 80
// a stalled result holds the register; a new item is taken in the same cycle
// the held result is taken, otherwise the input waits

module vend_motor_cycle_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: address_length[7:0], row_char[15:8], col_char[23:16],
    //        override_checks[24], sense_byte[32:25], zero pad[39:33]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,
    // tuser: req_type[0]
    input  logic [0:0]  i_s_tuser,
    // tdata: drive_first[7:0], drive_second[15:8], drive_third[23:16],
    //        busy_res[24], done_res[25], status[28:26], zero pad[31:29]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import vmc_pkg::*;

    // configuration
    logic               r_chiller;
    logic [LIMIT_W-1:0] r_leave_limit;
    logic [LIMIT_W-1:0] r_return_limit;

    // cycle state
    t_phase             r_phase, n_phase;
    logic [LIMIT_W-1:0] r_tick, n_tick;
    logic [23:0]        r_drive, n_drive;
    logic [2:0]         r_home_line, n_home_line;
    logic [2:0]         r_can_line, n_can_line;
    logic               r_drink, n_drink;
    logic               r_skip, n_skip;

    // result register
    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic [31:0]        n_out_data;

    logic               s_xfer;
    logic               in_req;
    logic [7:0]         in_len;
    logic [7:0]         in_row;
    logic [7:0]         in_col;
    logic               in_ovr;
    logic [7:0]         in_sense;
    logic               home;
    logic               can;
    logic               done;
    t_status            status;
    logic [LIMIT_W-1:0] tick_inc;
    logic [7:0]         first;
    t_vend_setup        setup;

    // input fields
    assign in_req   = i_s_tuser[0];
    assign in_len   = i_s_tdata[7:0];
    assign in_row   = i_s_tdata[15:8];
    assign in_col   = i_s_tdata[23:16];
    assign in_ovr   = i_s_tdata[24];
    assign in_sense = i_s_tdata[32:25];

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    vmc_addr_decode u_decode (
        .i_address_length (in_len),
        .i_row_char       (in_row),
        .i_col_char       (in_col),
        .o_setup          (setup)
    );

    assign home     = in_sense[r_home_line];
    assign can      = in_sense[r_can_line];
    assign tick_inc = r_tick + 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chiller      <= 1'b0;
            r_leave_limit  <= LEAVE_LIMIT_RST;
            r_return_limit <= RETURN_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CHILLER:      r_chiller      <= i_cfg_data[0];
                CFG_LEAVE_LIMIT:  r_leave_limit  <= i_cfg_data;
                CFG_RETURN_LIMIT: r_return_limit <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_drive     <= '0;
            r_home_line <= '0;
            r_can_line  <= '0;
            r_drink     <= 1'b0;
            r_skip      <= 1'b0;
        end else if (s_xfer) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_drive     <= n_drive;
            r_home_line <= n_home_line;
            r_can_line  <= n_can_line;
            r_drink     <= n_drink;
            r_skip      <= n_skip;
        end
    end

    // next phase, counters and completion code
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_drive     = r_drive;
        n_home_line = r_home_line;
        n_can_line  = r_can_line;
        n_drink     = r_drink;
        n_skip      = r_skip;
        done        = 1'b0;
        status      = ST_OK;
        if (in_req == REQ_VEND) begin
            // a request while a cycle runs is dropped
            if (r_phase == PH_IDLE) begin
                if (!setup.valid) begin
                    done   = 1'b1;
                    status = ST_BAD_ADDR;
                end else begin
                    n_drive     = setup.drive;
                    n_home_line = setup.home_line;
                    n_can_line  = setup.can_line;
                    n_drink     = setup.drink_row;
                    n_skip      = in_ovr;
                    n_tick      = '0;
                    n_phase     = PH_CHECK;
                end
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_CHECK, PH_LEAVE: begin
                    // check tick doubles as the first leave sample
                    if (r_phase == PH_CHECK && r_drink && !can && !r_skip) begin
                        done   = 1'b1;
                        status = ST_NO_CAN;
                    end else if (r_phase == PH_CHECK && !home && !r_skip) begin
                        done   = 1'b1;
                        status = ST_NOT_HOME;
                    end else if (!home) begin
                        n_phase = PH_RETURN;
                        n_tick  = '0;
                    end else if (tick_inc >= r_leave_limit) begin
                        done   = 1'b1;
                        status = ST_STUCK_HOME;
                    end else begin
                        n_phase = PH_LEAVE;
                        n_tick  = tick_inc;
                    end
                end
                PH_RETURN: begin
                    if (home) begin
                        done   = 1'b1;
                        status = ST_OK;
                    end else if (tick_inc >= r_return_limit) begin
                        done   = 1'b1;
                        status = ST_STUCK_AWAY;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                default: ;
            endcase
            // every exit stops the motor
            if (done) begin
                n_drive = '0;
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        end
    end

    // result word
    always_comb begin
        first      = n_drive[7:0] | (r_chiller ? CHILLER_BIT : 8'h00);
        n_out_data = {3'b000, status, done, (n_phase != PH_IDLE),
                      n_drive[23:16], n_drive[15:8], first};
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    // motor latches are off whenever no cycle runs
    a_idle_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_drive == '0)
        else $error("motor latches on while idle");

    // a running cycle drives exactly one column pair
    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> $onehot(r_drive[15:8]))
        else $error("column driver not one-hot during a cycle");

    // a finished cycle reports not busy with the column byte and the third latch byte off
    a_done_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[25] |-> !r_out_data[24] && r_out_data[23:8] == '0)
        else $error("completion reported with motor still driven");

    // every accepted item produces a pending result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> r_out_valid)
        else $error("accepted item left no result");

endmodule

// File: rtl/vmc_addr_decode.sv
// vmc_addr_decode: checks a row/column address and builds the motor latch bytes
// depends on vmc_pkg
`timescale 1ns / 1ps

module vmc_addr_decode (
    input  logic [7:0]           i_address_length,
    input  logic [7:0]           i_row_char,
    input  logic [7:0]           i_col_char,
    output vmc_pkg::t_vend_setup o_setup
);
    import vmc_pkg::*;

    logic [7:0] row_off;
    logic [2:0] col_pair;
    logic       col_odd;
    logic [2:0] row_bit;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;

    // row offset from A; E..G reuse the low two bits as 0..2
    assign row_off  = i_row_char - ROW_A;
    assign col_pair = i_col_char[3:1];
    assign col_odd  = i_col_char[0];
    assign row_bit  = {row_off[1:0], col_odd};

    // latch bytes: column pair one-hot, row bit by parity
    always_comb begin
        b0 = '0;
        b2 = '0;
        b1 = 8'd1 << col_pair;
        if (i_row_char <= ROW_D) begin
            b2 = 8'd1 << row_bit;
        end else begin
            b0 = 8'd1 << row_bit;
        end
    end

    // sensor lines and address check
    always_comb begin
        o_setup.valid = (i_address_length == ADDR_LEN)
                     && (i_row_char >= ROW_A) && (i_row_char <= ROW_G)
                     && (i_col_char >= CHAR_0) && (i_col_char <= CHAR_9);
        o_setup.drive     = {b2, b1, b0};
        o_setup.home_line = {2'b00, col_odd};
        o_setup.can_line  = '0;
        o_setup.drink_row = 1'b0;
        if (i_row_char == ROW_E) begin
            o_setup.home_line = HOME_LINE_E;
            o_setup.can_line  = CAN_LINE_E;
            o_setup.drink_row = 1'b1;
        end else if (i_row_char == ROW_F) begin
            o_setup.home_line = HOME_LINE_F;
            o_setup.can_line  = CAN_LINE_F;
            o_setup.drink_row = 1'b1;
        end
    end

endmodule
